// ===== src/scar_pkg.sv =====
`timescale 1ns / 1ps

package scar_pkg;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_RATE = 2'd0;
	localparam logic [1:0] REG_ROOM = 2'd1;
	localparam logic [1:0] REG_DAMP = 2'd2;
	localparam logic [1:0] REG_WET  = 2'd3;

	// Reset values and limits of the registers.
	localparam logic [16:0] RATE_RESET = 17'd48000;
	localparam logic [10:0] ROOM_RESET = 11'd410;
	localparam logic [15:0] DAMP_RESET = 16'd13107;
	localparam logic [16:0] WET_RESET  = 17'd16384;
	localparam logic [16:0] RATE_DEFAULT = 17'd48000;
	localparam logic [10:0] ROOM_MIN = 11'd51;
	localparam logic [10:0] ROOM_MAX = 11'd1024;
	localparam logic [15:0] DAMP_MAX = 16'd64880;
	localparam logic [16:0] WET_MAX  = 17'd65536;

	// Fixed-point constants: unity in Q1.16, comb feedback 0.8 in Q0.16, rounding half.
	localparam int Q16_ONE  = 65536;
	localparam int COMB_FB  = 52429;
	localparam int HALF_LSB = 32768;

	// Delay length scaling: round(base * rate * room / (48000 * 256)).
	// The divisor is 2^15 * 375: the dividend is shifted right by 15 bits and the
	// remaining division by 375 is a multiply by ceil(2^32 / 375) and a shift.
	localparam logic [39:0] LEN_HALF        = 40'd6144000;
	localparam int          LEN_PRE_SHIFT   = 15;
	localparam logic [23:0] LEN_RECIP       = 24'd11453247;
	localparam int          LEN_RECIP_SHIFT = 32;
	localparam int LEN_QW = 15;

	typedef enum logic [3:0] {
		L_CLEAR,
		L_IDLE,
		L_CRD,
		L_CMUL,
		L_CFIL,
		L_CWR,
		L_ARD,
		L_AWR,
		L_BL1,
		L_BL2,
		L_BL3,
		L_DONE
	} lane_state_t;

	typedef enum logic [2:0] {
		LC_IDLE,
		LC_PROD,
		LC_BASE,
		LC_DIV,
		LC_STORE
	} len_state_t;

	typedef struct packed {
		logic clear;
		logic start;
		logic take;
	} lane_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} lane_stat_t;

	function automatic logic [10:0] comb_base(input logic [2:0] i);
		logic [10:0] b;
		case (i)
			3'd0: b = 11'd1116;
			3'd1: b = 11'd1188;
			3'd2: b = 11'd1277;
			3'd3: b = 11'd1356;
			3'd4: b = 11'd1422;
			3'd5: b = 11'd1491;
			3'd6: b = 11'd1557;
			default: b = 11'd1617;
		endcase
		return b;
	endfunction

	function automatic logic [10:0] allpass_base(input logic [1:0] i);
		logic [10:0] b;
		case (i)
			2'd0: b = 11'd556;
			2'd1: b = 11'd441;
			2'd2: b = 11'd341;
			default: b = 11'd225;
		endcase
		return b;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== src/scar_stream_if.sv =====
`timescale 1ns / 1ps

// Input channel: one stereo sample per transaction.
interface scar_in_if #(parameter int W = 24);
	logic valid;
	logic ready;
	logic signed [W-1:0] left_in;
	logic signed [W-1:0] right_in;
	modport source(output valid, output left_in, output right_in, input ready);
	modport sink(input valid, input left_in, input right_in, output ready);
endinterface

// Output channel: one blended stereo sample per transaction.
interface scar_out_if #(parameter int W = 24);
	logic valid;
	logic ready;
	logic signed [W-1:0] left_out;
	logic signed [W-1:0] right_out;
	modport source(output valid, output left_out, output right_out, input ready);
	modport sink(input valid, input left_out, input right_out, output ready);
endinterface

// ===== src/scar_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module scar_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/scar_len_calc.sv =====
`timescale 1ns / 1ps

// Works out every delay length from rate and room, one stage after another.
// The division by the fixed scale is a shift followed by a reciprocal multiply.
module scar_len_calc #(
	parameter int NUM_COMBS = 4,
	parameter int NUM_ALLPASS = 3,
	parameter int MAX_COMB_DELAY = 16384,
	parameter int MAX_ALLPASS_DELAY = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [16:0] rate_eff,
	input  logic [10:0] room_eff,
	output logic        done,
	output logic [NUM_COMBS-1:0][$clog2(MAX_COMB_DELAY+1)-1:0]     comb_len,
	output logic [NUM_ALLPASS-1:0][$clog2(MAX_ALLPASS_DELAY+1)-1:0] ap_len
);

	localparam int NST = NUM_COMBS + NUM_ALLPASS;
	localparam int IW  = $clog2(NST);
	localparam int CLW = $clog2(MAX_COMB_DELAY + 1);
	localparam int ALW = $clog2(MAX_ALLPASS_DELAY + 1);

	scar_pkg::len_state_t state_q, state_d;
	logic [IW-1:0]   idx_q;
	logic [27:0]     rr_q;
	logic [39:0]     rem_q;
	logic [scar_pkg::LEN_QW-1:0] quot_q;
	logic [10:0]     base;
	logic [22:0]     scaled;
	logic [46:0]     qprod;
	logic            last_stage;
	int              nlen;

	// Base length of the stage being worked on, and the reciprocal product.
	always_comb begin
		if (int'(idx_q) < NUM_COMBS) begin
			base = scar_pkg::comb_base(3'(idx_q));
		end else begin
			base = scar_pkg::allpass_base(2'(idx_q - IW'(NUM_COMBS)));
		end
		scaled = 23'(rem_q >> scar_pkg::LEN_PRE_SHIFT);
		qprod  = 47'(scaled) * 47'(scar_pkg::LEN_RECIP);
		last_stage = (int'(idx_q) == NST - 1);
		nlen = (quot_q < scar_pkg::LEN_QW'(2)) ? 2 : int'(quot_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			scar_pkg::LC_IDLE:  state_d = scar_pkg::LC_IDLE;
			scar_pkg::LC_PROD:  state_d = scar_pkg::LC_BASE;
			scar_pkg::LC_BASE:  state_d = scar_pkg::LC_DIV;
			scar_pkg::LC_DIV:   state_d = scar_pkg::LC_STORE;
			scar_pkg::LC_STORE: state_d = last_stage ? scar_pkg::LC_IDLE : scar_pkg::LC_BASE;
			default:            state_d = scar_pkg::LC_IDLE;
		endcase
		if (start) begin
			state_d = scar_pkg::LC_PROD;
		end
	end

	// Outputs.
	always_comb begin
		done = (state_q == scar_pkg::LC_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scar_pkg::LC_PROD;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				idx_q <= '0;
			end else if (state_q == scar_pkg::LC_STORE) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	// Datapath: product, divide and clamp.
	always_ff @(posedge clk) begin
		case (state_q)
			scar_pkg::LC_PROD: begin
				rr_q <= 28'(rate_eff) * 28'(room_eff);
			end
			scar_pkg::LC_BASE: begin
				rem_q <= 40'(rr_q) * 40'(base) + scar_pkg::LEN_HALF;
			end
			scar_pkg::LC_DIV: begin
				quot_q <= scar_pkg::LEN_QW'(qprod >> scar_pkg::LEN_RECIP_SHIFT);
			end
			scar_pkg::LC_STORE: begin
				for (int i = 0; i < NUM_COMBS; i++) begin
					if (int'(idx_q) == i) begin
						comb_len[i] <= CLW'((nlen > MAX_COMB_DELAY) ? MAX_COMB_DELAY : nlen);
					end
				end
				for (int i = 0; i < NUM_ALLPASS; i++) begin
					if (int'(idx_q) == NUM_COMBS + i) begin
						ap_len[i] <= ALW'((nlen > MAX_ALLPASS_DELAY) ? MAX_ALLPASS_DELAY : nlen);
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== src/scar_lane.sv =====
`timescale 1ns / 1ps

// One channel of the reverb: combs and allpasses stepped one stage at a time,
// with the delay lines held in two RAMs, then the wet/dry blend.
module scar_lane #(
	parameter int NUM_COMBS = 4,
	parameter int NUM_ALLPASS = 3,
	parameter int MAX_COMB_DELAY = 16384,
	parameter int MAX_ALLPASS_DELAY = 8192,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  scar_pkg::lane_ctl_t     ctl,
	output scar_pkg::lane_stat_t    stat,
	input  logic signed [SAMPLE_WIDTH-1:0] x,
	input  logic [15:0]             damp_eff,
	input  logic [16:0]             wet_eff,
	input  logic [NUM_COMBS-1:0][$clog2(MAX_COMB_DELAY+1)-1:0]     comb_len,
	input  logic [NUM_ALLPASS-1:0][$clog2(MAX_ALLPASS_DELAY+1)-1:0] ap_len,
	output logic signed [SAMPLE_WIDTH-1:0] result
);

	localparam int CDEPTH = NUM_COMBS * MAX_COMB_DELAY;
	localparam int ADEPTH = NUM_ALLPASS * MAX_ALLPASS_DELAY;
	localparam int MAXD = (CDEPTH > ADEPTH) ? CDEPTH : ADEPTH;
	localparam int CLRW = $clog2(MAXD);
	localparam int CAW = $clog2(CDEPTH);
	localparam int AAW = $clog2(ADEPTH);
	localparam int CIW = (NUM_COMBS > 1) ? $clog2(NUM_COMBS) : 1;
	localparam int AIW = (NUM_ALLPASS > 1) ? $clog2(NUM_ALLPASS) : 1;
	localparam int CPW = $clog2(MAX_COMB_DELAY);
	localparam int APW = $clog2(MAX_ALLPASS_DELAY);
	localparam int CLW = $clog2(MAX_COMB_DELAY + 1);
	localparam int ALW = $clog2(MAX_ALLPASS_DELAY + 1);

	scar_pkg::lane_state_t state_q, state_d;
	logic [CLRW-1:0] clr_q;
	logic [CIW-1:0]  st_q;
	logic [AIW-1:0]  ast_q;
	logic [CPW-1:0]  cpos_q [NUM_COMBS];
	logic [APW-1:0]  apos_q [NUM_ALLPASS];
	logic signed [31:0] lp_q [NUM_COMBS];
	logic signed [31:0] x_q, y_q, fil_q, s_q;
	logic signed [34:0] sum_q;
	logic signed [50:0] prod_q;
	logic signed [49:0] pa_q, pb_q;
	logic signed [SAMPLE_WIDTH-1:0] res_q;

	logic            c_we, c_re, a_we, a_re;
	logic [CAW-1:0]  c_addr, c_waddr;
	logic [AAW-1:0]  a_addr, a_waddr;
	logic [31:0]     c_wdata, a_wdata, c_rdata, a_rdata;
	logic [CLW-1:0]  cnext;
	logic [ALW-1:0]  anext;
	logic signed [32:0] diff;
	logic signed [17:0] dcoef, wcoef, wgain;
	logic signed [47:0] fb_prod;
	logic signed [31:0] fil_d;
	logic signed [50:0] blend;
	logic signed [34:0] blend_r;
	logic signed [34:0] out_hi, out_lo;
	logic            last_clr, last_comb, last_ap;

	// Arithmetic shared by the sequencer steps.
	always_comb begin
		c_addr   = CAW'(int'(st_q) * MAX_COMB_DELAY + int'(cpos_q[st_q]));
		a_addr   = AAW'(int'(ast_q) * MAX_ALLPASS_DELAY + int'(apos_q[ast_q]));
		cnext    = CLW'(cpos_q[st_q]) + CLW'(1);
		anext    = ALW'(apos_q[ast_q]) + ALW'(1);
		dcoef    = 18'(scar_pkg::Q16_ONE) - 18'(damp_eff);
		wcoef    = 18'(scar_pkg::Q16_ONE) - 18'(wet_eff);
		wgain    = 18'(wet_eff);
		diff     = 33'(lp_q[st_q]) - 33'(signed'(c_rdata));
		fil_d    = scar_pkg::sat32(64'(y_q) + 64'((prod_q + 51'(scar_pkg::HALF_LSB)) >>> 16));
		fb_prod  = 48'(fil_q) * 48'(signed'(18'(scar_pkg::COMB_FB)));
		blend    = 51'(pa_q) + 51'(pb_q) + 51'(scar_pkg::HALF_LSB);
		blend_r  = 35'(blend >>> 16);
		out_hi   = 35'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
		out_lo   = -out_hi - 35'sd1;
		last_clr  = (int'(clr_q) == MAXD - 1);
		last_comb = (int'(st_q) == NUM_COMBS - 1);
		last_ap   = (int'(ast_q) == NUM_ALLPASS - 1);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			scar_pkg::L_CLEAR: state_d = last_clr ? scar_pkg::L_IDLE : scar_pkg::L_CLEAR;
			scar_pkg::L_IDLE:  state_d = ctl.start ? scar_pkg::L_CRD : scar_pkg::L_IDLE;
			scar_pkg::L_CRD:   state_d = scar_pkg::L_CMUL;
			scar_pkg::L_CMUL:  state_d = scar_pkg::L_CFIL;
			scar_pkg::L_CFIL:  state_d = scar_pkg::L_CWR;
			scar_pkg::L_CWR:   state_d = last_comb ? scar_pkg::L_ARD : scar_pkg::L_CRD;
			scar_pkg::L_ARD:   state_d = scar_pkg::L_AWR;
			scar_pkg::L_AWR:   state_d = last_ap ? scar_pkg::L_BL1 : scar_pkg::L_ARD;
			scar_pkg::L_BL1:   state_d = scar_pkg::L_BL2;
			scar_pkg::L_BL2:   state_d = scar_pkg::L_BL3;
			scar_pkg::L_BL3:   state_d = scar_pkg::L_DONE;
			scar_pkg::L_DONE:  state_d = ctl.take ? scar_pkg::L_IDLE : scar_pkg::L_DONE;
			default:           state_d = scar_pkg::L_CLEAR;
		endcase
		if (ctl.clear) begin
			state_d = scar_pkg::L_CLEAR;
		end
	end

	// Outputs: memory strobes, write data and status.
	always_comb begin
		c_we    = 1'b0;
		c_re    = 1'b0;
		a_we    = 1'b0;
		a_re    = 1'b0;
		c_waddr = c_addr;
		a_waddr = a_addr;
		c_wdata = scar_pkg::sat32(64'(x_q) + 64'((fb_prod + 48'(scar_pkg::HALF_LSB)) >>> 16));
		a_wdata = scar_pkg::sat32(64'(s_q) + 64'(signed'(a_rdata) >>> 1));
		case (state_q)
			scar_pkg::L_CLEAR: begin
				c_we    = (int'(clr_q) < CDEPTH);
				a_we    = (int'(clr_q) < ADEPTH);
				c_waddr = CAW'(clr_q);
				a_waddr = AAW'(clr_q);
				c_wdata = '0;
				a_wdata = '0;
			end
			scar_pkg::L_CRD: c_re = 1'b1;
			scar_pkg::L_CWR: c_we = 1'b1;
			scar_pkg::L_ARD: a_re = 1'b1;
			scar_pkg::L_AWR: a_we = 1'b1;
			default: begin
			end
		endcase
		stat.idle = (state_q == scar_pkg::L_IDLE);
		stat.done = (state_q == scar_pkg::L_DONE);
		result    = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scar_pkg::L_CLEAR;
			clr_q   <= '0;
			st_q    <= '0;
			ast_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.clear) begin
				clr_q <= '0;
			end else if (state_q == scar_pkg::L_CLEAR) begin
				clr_q <= clr_q + CLRW'(1);
			end
			if (state_q == scar_pkg::L_IDLE) begin
				st_q  <= '0;
				ast_q <= '0;
			end else if (state_q == scar_pkg::L_CWR) begin
				st_q <= last_comb ? '0 : st_q + CIW'(1);
			end else if (state_q == scar_pkg::L_AWR) begin
				ast_q <= last_ap ? '0 : ast_q + AIW'(1);
			end
		end
	end

	// Filter state and datapath registers, stepped by the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			scar_pkg::L_CLEAR: begin
				for (int i = 0; i < NUM_COMBS; i++) begin
					lp_q[i]   <= '0;
					cpos_q[i] <= '0;
				end
				for (int i = 0; i < NUM_ALLPASS; i++) begin
					apos_q[i] <= '0;
				end
			end
			scar_pkg::L_IDLE: begin
				x_q   <= 32'(x);
				sum_q <= '0;
			end
			scar_pkg::L_CMUL: begin
				y_q    <= signed'(c_rdata);
				prod_q <= 51'(diff) * 51'(dcoef);
				sum_q  <= sum_q + 35'(signed'(c_rdata));
			end
			scar_pkg::L_CFIL: begin
				fil_q      <= fil_d;
				lp_q[st_q] <= fil_d;
			end
			scar_pkg::L_CWR: begin
				cpos_q[st_q] <= (cnext >= comb_len[st_q]) ? '0 : CPW'(cnext);
				if (last_comb) begin
					s_q <= scar_pkg::sat32(64'(sum_q));
				end
			end
			scar_pkg::L_AWR: begin
				apos_q[ast_q] <= (anext >= ap_len[ast_q]) ? '0 : APW'(anext);
				s_q <= scar_pkg::sat32(64'(signed'(a_rdata)) - 64'(s_q));
			end
			scar_pkg::L_BL1: pa_q <= 50'(x_q) * 50'(wcoef);
			scar_pkg::L_BL2: pb_q <= 50'(s_q) * 50'(wgain);
			scar_pkg::L_BL3: begin
				if (blend_r > out_hi) begin
					res_q <= SAMPLE_WIDTH'(out_hi);
				end else if (blend_r < out_lo) begin
					res_q <= SAMPLE_WIDTH'(out_lo);
				end else begin
					res_q <= SAMPLE_WIDTH'(blend_r);
				end
			end
			default: begin
			end
		endcase
	end

	scar_ram #(.WIDTH(32), .DEPTH(CDEPTH)) u_comb_ram (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.re(c_re), .raddr(c_addr), .rdata(c_rdata)
	);

	scar_ram #(.WIDTH(32), .DEPTH(ADEPTH)) u_ap_ram (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.re(a_re), .raddr(a_addr), .rdata(a_rdata)
	);

endmodule

// ===== src/stereo_comb_allpass_reverb_unit.sv =====
`timescale 1ns / 1ps

// Stereo comb/allpass reverb.
// in_ch carries one left and one right sample per transaction; out_ch returns
// the blended pair, one result per input, in order. Registers sit on the APB
// port: sample rate, room size, damping and wet mix at byte addresses 0, 4, 8, 12.
// Both channels run as two lanes in lockstep; an output register merges them.
// Each lane steps through its combs (states CRD, CMUL, CFIL and CWR, set by the comb RAM
// read and two multiplies) and allpasses (ARD and AWR), then a blend in BL1 to BL3;
// a new item is accepted only after both lanes have handed the last one over, and
// the result is shown from the output register that takes it from the lanes.
// in_ch.ready is high only while both lanes are idle.
// After reset, and after every write of rate or room, the lanes clear their delay
// RAMs at one entry a cycle, max(NUM_COMBS*MAX_COMB_DELAY, NUM_ALLPASS*
// MAX_ALLPASS_DELAY) entries (65536 by default), while the delay lengths are
// recomputed; no input is accepted meanwhile.
// When the receiver stalls, the finished pair waits in the output register and the
// lanes may finish one more item, which then waits until the register is free.
module stereo_comb_allpass_reverb_unit #(
	parameter int MAX_COMB_DELAY = 16384,
	parameter int MAX_ALLPASS_DELAY = 8192,
	parameter int NUM_COMBS = 4,
	parameter int NUM_ALLPASS = 3,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	scar_in_if.sink     in_ch,
	scar_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CLW = $clog2(MAX_COMB_DELAY + 1);
	localparam int ALW = $clog2(MAX_ALLPASS_DELAY + 1);

	logic [16:0] rate_q, wet_q;
	logic [10:0] room_q;
	logic [15:0] damp_q;
	logic [16:0] rate_eff, wet_eff;
	logic [10:0] room_eff;
	logic [15:0] damp_eff;
	logic        cfg_wr, rebuild, len_done, take;
	logic [1:0]  reg_idx;
	logic [NUM_COMBS-1:0][CLW-1:0]   comb_len;
	logic [NUM_ALLPASS-1:0][ALW-1:0] ap_len;
	scar_pkg::lane_ctl_t  ctl;
	scar_pkg::lane_stat_t stat_l, stat_r;
	logic signed [SAMPLE_WIDTH-1:0] res_l, res_r;
	logic        out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] left_q, right_q;

	// Configuration port decode and read-back.
	always_comb begin
		pready  = 1'b1;
		reg_idx = paddr[3:2];
		cfg_wr  = psel && penable && pwrite;
		rebuild = cfg_wr && (reg_idx == scar_pkg::REG_RATE || reg_idx == scar_pkg::REG_ROOM);
		case (reg_idx)
			scar_pkg::REG_RATE: prdata = 32'(rate_q);
			scar_pkg::REG_ROOM: prdata = 32'(room_q);
			scar_pkg::REG_DAMP: prdata = 32'(damp_q);
			scar_pkg::REG_WET:  prdata = 32'(wet_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= scar_pkg::RATE_RESET;
			room_q <= scar_pkg::ROOM_RESET;
			damp_q <= scar_pkg::DAMP_RESET;
			wet_q  <= scar_pkg::WET_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				scar_pkg::REG_RATE: rate_q <= pwdata[16:0];
				scar_pkg::REG_ROOM: room_q <= pwdata[10:0];
				scar_pkg::REG_DAMP: damp_q <= pwdata[15:0];
				scar_pkg::REG_WET:  wet_q  <= pwdata[16:0];
				default: begin
				end
			endcase
		end
	end

	// Register values as the arithmetic uses them: defaulted and clamped.
	always_comb begin
		rate_eff = (rate_q == '0) ? scar_pkg::RATE_DEFAULT : rate_q;
		if (room_q > scar_pkg::ROOM_MAX) begin
			room_eff = scar_pkg::ROOM_MAX;
		end else if (room_q < scar_pkg::ROOM_MIN) begin
			room_eff = scar_pkg::ROOM_MIN;
		end else begin
			room_eff = room_q;
		end
		damp_eff = (damp_q > scar_pkg::DAMP_MAX) ? scar_pkg::DAMP_MAX : damp_q;
		wet_eff  = (wet_q > scar_pkg::WET_MAX) ? scar_pkg::WET_MAX : wet_q;
	end

	// Lane control: both lanes start, finish and hand over together.
	always_comb begin
		in_ch.ready = stat_l.idle && stat_r.idle && len_done;
		take        = stat_l.done && stat_r.done && (!out_valid_q || out_ch.ready);
		ctl.clear   = rebuild;
		ctl.start   = in_ch.valid && in_ch.ready;
		ctl.take    = take;
		out_ch.valid     = out_valid_q;
		out_ch.left_out  = left_q;
		out_ch.right_out = right_q;
	end

	// Merging stage: the output register holds one stereo pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			left_q  <= res_l;
			right_q <= res_r;
		end
	end

	scar_len_calc #(
		.NUM_COMBS(NUM_COMBS), .NUM_ALLPASS(NUM_ALLPASS),
		.MAX_COMB_DELAY(MAX_COMB_DELAY), .MAX_ALLPASS_DELAY(MAX_ALLPASS_DELAY)
	) u_len (
		.clk(clk), .arst_n(arst_n), .start(rebuild),
		.rate_eff(rate_eff), .room_eff(room_eff),
		.done(len_done), .comb_len(comb_len), .ap_len(ap_len)
	);

	scar_lane #(
		.NUM_COMBS(NUM_COMBS), .NUM_ALLPASS(NUM_ALLPASS),
		.MAX_COMB_DELAY(MAX_COMB_DELAY), .MAX_ALLPASS_DELAY(MAX_ALLPASS_DELAY),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_lane_l (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .stat(stat_l), .x(in_ch.left_in),
		.damp_eff(damp_eff), .wet_eff(wet_eff), .comb_len(comb_len), .ap_len(ap_len),
		.result(res_l)
	);

	scar_lane #(
		.NUM_COMBS(NUM_COMBS), .NUM_ALLPASS(NUM_ALLPASS),
		.MAX_COMB_DELAY(MAX_COMB_DELAY), .MAX_ALLPASS_DELAY(MAX_ALLPASS_DELAY),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_lane_r (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .stat(stat_r), .x(in_ch.right_in),
		.damp_eff(damp_eff), .wet_eff(wet_eff), .comb_len(comb_len), .ap_len(ap_len),
		.result(res_r)
	);

endmodule

// ===== src/scar_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks on the reverb unit.
module scar_checker #(
	parameter int W = 24
) (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input logic [W-1:0] left_out,
	input logic [W-1:0] right_out,
	input logic         cfg_wr,
	input logic [1:0]   cfg_idx
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(left_out) && $stable(right_out))
		else $error("output payload changed while stalled");

	// One sample at a time: after a transaction the lanes are busy.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	// A rate or room write starts the clearing pass.
	a_rebuild_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && (cfg_idx == scar_pkg::REG_RATE || cfg_idx == scar_pkg::REG_ROOM)
		|=> !in_ready)
		else $error("input ready straight after a delay length change");

endmodule

bind stereo_comb_allpass_reverb_unit scar_checker #(.W(SAMPLE_WIDTH)) u_scar_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.left_out(out_ch.left_out),
	.right_out(out_ch.right_out),
	.cfg_wr(psel && penable && pwrite),
	.cfg_idx(paddr[3:2])
);
